// ===== sv/dc_pkg.sv =====
// Package: shared constants, codes and widths for the door controller.
`default_nettype none
package dc_pkg;
    localparam int DC_DIV_W = 57;
    localparam int DC_DIV_CW = 6;
    localparam logic [1:0] MODE_CLOSED  = 2'd0;
    localparam logic [1:0] MODE_OPEN    = 2'd1;
    localparam logic [1:0] MODE_OPENING = 2'd2;
    localparam logic [1:0] MODE_CLOSING = 2'd3;
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_PRESS  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [2:0] REG_KP        = 3'd0;
    localparam logic [2:0] REG_KI        = 3'd1;
    localparam logic [2:0] REG_KD        = 3'd2;
    localparam logic [2:0] REG_OPEN_POS  = 3'd3;
    localparam logic [2:0] REG_CLOSE_POS = 3'd4;
    localparam logic [2:0] REG_BAND      = 3'd5;
    localparam logic [2:0] REG_OPEN_SEC  = 3'd6;
    localparam logic [2:0] REG_OFFSET    = 3'd7;
    typedef logic [DC_DIV_W-1:0] t_div_word;
endpackage
`default_nettype wire

// ===== sv/dc_if.sv =====
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface dc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] position;
    logic [23:0] elapsed_time;
    logic        button_held;
    modport source (output valid, cmd, position, elapsed_time, button_held, input ready);
    modport sink (input valid, cmd, position, elapsed_time, button_held, output ready);
endinterface

interface dc_out_if;
    logic        valid;
    logic        ready;
    logic        motor_on;
    logic        motor_reverse;
    logic [15:0] motor_speed;
    logic [1:0]  door_status;
    modport source (output valid, motor_on, motor_reverse, motor_speed, door_status,
                    input ready);
    modport sink (input valid, motor_on, motor_reverse, motor_speed, door_status,
                  output ready);
endinterface

interface dc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/dc_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none
module dc_mul
    import dc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== sv/dc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dc_div
    import dc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_div_word   i_dividend,
    input  wire logic [23:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output t_div_word        o_quot
);
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DC_DIV_CW-1:0]  r_cnt, n_cnt;
    logic [24:0]           r_rem, n_rem;
    t_div_word             r_q, n_q;
    logic [23:0]           r_dvs, n_dvs;
    logic [24:0]           trial;
    logic [25:0]           diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        trial  = {r_rem[23:0], r_q[DC_DIV_W-1]};
        diff   = {1'b0, trial} - {2'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DC_DIV_CW'(DC_DIV_W - 1);
            n_rem  = 25'd0;
            n_q    = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (diff[25]) begin
                n_rem = trial;
                n_q   = {r_q[DC_DIV_W-2:0], 1'b0};
            end else begin
                n_rem = diff[24:0];
                n_q   = {r_q[DC_DIV_W-2:0], 1'b1};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== sv/door_controller_with_pid_positioning.sv =====
// Top level: door mode sequencer with PID step over a shared multiplier and divider.
// Usage:
//   i_item carries one command: position sample, button press edge or one-second
//   tick. o_result returns exactly one item per command with motor drive and
//   door mode after that command. i_cfg writes the gain, target, band, hold
//   time and speed offset registers; it is always ready.
//   Press, tick and ignored samples go from decode straight to the result.
//   A PID sample runs five products on the 32x32 multiplier and, when
//   elapsed_time is nonzero, the 57-bit restoring divider for the
//   derivative term.
//   One item is processed at a time; i_item.ready is high only when idle.
//   A stalled result is held in the output register; the next item is taken
//   meanwhile, but its result waits until the held one is taken.
//   Reset restores register defaults, closed mode and released motor.
`default_nettype none
module door_controller_with_pid_positioning
    import dc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dc_in_if.sink     i_item,
    dc_cfg_if.sink    i_cfg,
    dc_out_if.source  o_result
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_INT  = 4'd2;
    localparam logic [3:0] S_P    = 4'd3;
    localparam logic [3:0] S_IL   = 4'd4;
    localparam logic [3:0] S_IH   = 4'd5;
    localparam logic [3:0] S_D    = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [31:0] r_kp, r_ki, r_kd;
    logic [15:0] r_open_pos, r_close_pos;
    logic [7:0]  r_band, r_open_sec;
    logic [11:0] r_offset;

    logic [3:0]         r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [7:0]         r_sec, n_sec;
    logic signed [63:0] r_integral, n_integral;
    logic signed [16:0] r_last_err, n_last_err;
    logic               r_rev, n_rev;
    logic               r_on, n_on;
    logic [15:0]        r_speed, n_speed;

    logic [1:0]         r_cmd, n_cmd;
    logic [15:0]        r_pos, n_pos;
    logic [23:0]        r_dt, n_dt;
    logic               r_held, n_held;
    logic               r_was_open, n_was_open;
    logic signed [16:0] r_err, n_err;
    logic [48:0]        r_p, n_p;
    logic [63:0]        r_ilo, n_ilo;
    logic [54:0]        r_i, n_i;
    t_div_word          r_dm, n_dm;
    t_div_word          r_d, n_d;

    logic        r_ov, n_ov;
    logic        r_o_on, n_o_on;
    logic        r_o_rev, n_o_rev;
    logic [15:0] r_o_speed, n_o_speed;
    logic [1:0]  r_o_mode, n_o_mode;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        r_div_go;
    logic        div_busy, div_done;
    t_div_word   div_quot;

    logic [15:0]        target;
    logic signed [16:0] err_now;
    logic [16:0]        aerr_now, aerr_r;
    logic signed [17:0] diff;
    logic [17:0]        adiff;
    logic [62:0]        abs_int;
    logic signed [41:0] eprod;
    logic signed [64:0] isum;
    logic [65:0]        ifull;
    logic [62:0]        imag;
    logic signed [63:0] ps, is, ds, sum;
    logic [63:0]        asum;
    logic [39:0]        dmag;
    logic [15:0]        dclip;
    logic               fin_go;

    dc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    dc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_dm),
        .i_divisor  (r_dt),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign target   = (r_mode == MODE_OPENING) ? r_open_pos : r_close_pos;
    assign err_now  = $signed({1'b0, target}) - $signed({1'b0, r_pos});
    assign aerr_now = err_now[16] ? 17'(-err_now) : 17'(err_now);
    assign aerr_r   = r_err[16] ? 17'(-r_err) : 17'(r_err);
    assign diff     = 18'(r_err) - 18'(r_last_err);
    assign adiff    = diff[17] ? 18'(-diff) : 18'(diff);
    assign abs_int  = r_integral[63] ? 63'(-r_integral) : 63'(r_integral);
    assign eprod    = r_err[16] ? -$signed({1'b0, mul_p[40:0]}) : $signed({1'b0, mul_p[40:0]});
    assign isum     = 65'(r_integral) + 65'(eprod);
    assign ifull    = {2'b0, mul_p[29:0], 32'b0} + 66'(r_ilo);
    assign fin_go   = !r_ov || o_result.ready;

    always_comb begin
        if (mul_p[63:30] != '0) begin
            imag = 63'd1 << 62;
        end else if (ifull >= (66'd1 << 62)) begin
            imag = 63'd1 << 62;
        end else begin
            imag = ifull[62:0];
        end
    end

    always_comb begin
        ps    = r_err[16] ? -$signed(64'(r_p)) : $signed(64'(r_p));
        is    = r_integral[63] ? -$signed(64'(r_i)) : $signed(64'(r_i));
        ds    = diff[17] ? -$signed(64'(r_d)) : $signed(64'(r_d));
        sum   = ps + is + ds;
        asum  = sum[63] ? 64'(-sum) : 64'(sum);
        dmag  = asum[63:24];
        if (sum[63]) begin
            dclip = (dmag > 40'd32768) ? 16'd32768 : dmag[15:0];
        end else begin
            dclip = (dmag > 40'd32767) ? 16'd32767 : dmag[15:0];
        end
    end

    always_comb begin
        case (r_state)
            S_DEC: begin
                mul_a = 32'(aerr_now);
                mul_b = 32'(r_dt);
            end
            S_INT: begin
                mul_a = 32'(aerr_r);
                mul_b = r_kp;
            end
            S_P: begin
                mul_a = abs_int[31:0];
                mul_b = r_ki;
            end
            S_IL: begin
                mul_a = {1'b0, abs_int[62:32]};
                mul_b = r_ki;
            end
            S_IH: begin
                mul_a = 32'(adiff);
                mul_b = r_kd;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_sec      = r_sec;
        n_integral = r_integral;
        n_last_err = r_last_err;
        n_rev      = r_rev;
        n_on       = r_on;
        n_speed    = r_speed;
        n_cmd      = r_cmd;
        n_pos      = r_pos;
        n_dt       = r_dt;
        n_held     = r_held;
        n_was_open = r_was_open;
        n_err      = r_err;
        n_p        = r_p;
        n_ilo      = r_ilo;
        n_i        = r_i;
        n_dm       = r_dm;
        n_d        = r_d;
        n_ov       = r_ov && !o_result.ready;
        n_o_on     = r_o_on;
        n_o_rev    = r_o_rev;
        n_o_speed  = r_o_speed;
        n_o_mode   = r_o_mode;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_cmd      = i_item.cmd;
                    n_pos      = i_item.position;
                    n_dt       = i_item.elapsed_time;
                    n_held     = i_item.button_held;
                    n_was_open = (r_mode == MODE_OPEN);
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                case (r_cmd)
                    CMD_SAMPLE: begin
                        if (r_mode == MODE_OPENING || r_mode == MODE_CLOSING) begin
                            if (aerr_now <= 17'(r_band)) begin
                                n_on       = 1'b0;
                                n_speed    = 16'd0;
                                n_integral = 64'sd0;
                                if (r_mode == MODE_OPENING) begin
                                    n_mode = MODE_OPEN;
                                    n_sec  = 8'd0;
                                end else begin
                                    n_mode = MODE_CLOSED;
                                end
                            end else begin
                                n_rev   = err_now[16];
                                n_err   = err_now;
                                n_state = S_INT;
                            end
                        end
                    end
                    CMD_PRESS: begin
                        if (r_mode == MODE_CLOSED || r_mode == MODE_CLOSING) begin
                            n_mode = MODE_OPENING;
                        end else if (r_mode == MODE_OPEN) begin
                            n_sec = 8'd0;
                        end
                    end
                    CMD_TICK: begin
                        if (r_sec != 8'hFF) begin
                            n_sec = r_sec + 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INT: begin
                if (isum > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
                    n_integral = 64'sh7FFF_FFFF_FFFF_FFFF;
                end else if (isum < -65'sh0_7FFF_FFFF_FFFF_FFFF) begin
                    n_integral = -64'sh7FFF_FFFF_FFFF_FFFF;
                end else begin
                    n_integral = isum[63:0];
                end
                n_state = S_P;
            end
            S_P: begin
                n_p     = mul_p[48:0];
                n_state = S_IL;
            end
            S_IL: begin
                n_ilo   = mul_p;
                n_state = S_IH;
            end
            S_IH: begin
                n_i     = imag[62:8];
                n_state = S_D;
            end
            S_D: begin
                n_dm = {mul_p[48:0], 8'b0};
                if (r_dt == 24'd0) begin
                    n_d     = '0;
                    n_state = S_SUM;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_d     = div_quot;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_on       = 1'b1;
                n_speed    = 16'(17'(dclip) + 17'(r_offset));
                n_last_err = r_err;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    if (r_was_open && r_mode == MODE_OPEN) begin
                        if (r_held) begin
                            n_sec = 8'd0;
                        end else if (r_sec >= r_open_sec) begin
                            n_mode = MODE_CLOSING;
                        end
                    end
                    n_ov      = 1'b1;
                    n_o_on    = r_on;
                    n_o_rev   = r_rev;
                    n_o_speed = r_on ? r_speed : 16'd0;
                    n_o_mode  = n_mode;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= (r_state == S_D) && (r_dt != 24'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= 32'd3355443;
            r_ki        <= 32'd252;
            r_kd        <= 32'd167772160;
            r_open_pos  <= 16'd1374;
            r_close_pos <= 16'd1000;
            r_band      <= 8'd5;
            r_open_sec  <= 8'd5;
            r_offset    <= 12'd150;
            r_state     <= S_IDLE;
            r_mode      <= MODE_CLOSED;
            r_sec       <= 8'd0;
            r_integral  <= 64'sd0;
            r_last_err  <= 17'sd0;
            r_rev       <= 1'b0;
            r_on        <= 1'b0;
            r_speed     <= 16'd0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_KP:        r_kp        <= i_cfg.data;
                    REG_KI:        r_ki        <= i_cfg.data;
                    REG_KD:        r_kd        <= i_cfg.data;
                    REG_OPEN_POS:  r_open_pos  <= i_cfg.data[15:0];
                    REG_CLOSE_POS: r_close_pos <= i_cfg.data[15:0];
                    REG_BAND:      r_band      <= i_cfg.data[7:0];
                    REG_OPEN_SEC:  r_open_sec  <= i_cfg.data[7:0];
                    REG_OFFSET:    r_offset    <= i_cfg.data[11:0];
                    default: begin
                    end
                endcase
            end
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_sec      <= n_sec;
            r_integral <= n_integral;
            r_last_err <= n_last_err;
            r_rev      <= n_rev;
            r_on       <= n_on;
            r_speed    <= n_speed;
            r_ov       <= n_ov;
        end
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_dt       <= n_dt;
        r_held     <= n_held;
        r_was_open <= n_was_open;
        r_err      <= n_err;
        r_p        <= n_p;
        r_ilo      <= n_ilo;
        r_i        <= n_i;
        r_dm       <= n_dm;
        r_d        <= n_d;
        r_o_on     <= n_o_on;
        r_o_rev    <= n_o_rev;
        r_o_speed  <= n_o_speed;
        r_o_mode   <= n_o_mode;
    end

    assign o_result.valid         = r_ov;
    assign o_result.motor_on      = r_o_on;
    assign o_result.motor_reverse = r_o_rev;
    assign o_result.motor_speed   = r_o_speed;
    assign o_result.door_status   = r_o_mode;

    a_idle_mode_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && (r_mode == MODE_OPEN || r_mode == MODE_CLOSED)) |-> !r_on)
        else $error("motor driven while door is at rest");
    a_idle_integral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_on) |-> (r_integral == 64'sd0))
        else $error("integral kept after move end");
    a_div_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dt != 24'd0))
        else $error("divide by zero elapsed time");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");
endmodule
`default_nettype wire
